@@ rtl/scan_range_outlier_filter_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Scan range outlier filter assertion macros
// Shared concurrent assertion shorthands for the filter modules.
// ---------------------------------------------------------------------------
`ifndef SCAN_RANGE_OUTLIER_FILTER_UNIT_MACROS_SVH
`define SCAN_RANGE_OUTLIER_FILTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SROF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SROF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/srof_pkg.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter package
// Register map, configuration record and result queue constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srof_pkg;

   localparam int CFG_WIDTH     = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CFG_WIDTH-1:0] RANGE_MIN_RESET    = 16'd0;
   localparam logic [CFG_WIDTH-1:0] RANGE_MAX_RESET    = 16'd30000;
   localparam logic [CFG_WIDTH-1:0] MIN_DIST_RESET     = 16'd0;
   localparam logic [CFG_WIDTH-1:0] NEIGHBOR_DIST_RESET = 16'd0;

   typedef enum logic [1:0] {
      REG_RANGE_MIN     = 2'd0,
      REG_RANGE_MAX     = 2'd1,
      REG_MIN_DIST      = 2'd2,
      REG_NEIGHBOR_DIST = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] lower_mm;
      logic [CFG_WIDTH-1:0] upper_mm;
      logic [CFG_WIDTH-1:0] closest_mm;
      logic [CFG_WIDTH-1:0] support_mm;
   } cfg_type;

   localparam int OQ_DEPTH    = 4;
   localparam int OQ_PTR_BITS = 2;
   localparam int OQ_CNT_BITS = 3;

endpackage

@@ rtl/srof_csr.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter configuration registers
// APB-style register file holding the four 16-bit filter thresholds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srof_csr
   import srof_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type sel;
   logic        wr_en;

   assign sel        = csr_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            REG_RANGE_MIN:     cfg_in.lower_mm   = csr_pwdata[CFG_WIDTH-1:0];
            REG_RANGE_MAX:     cfg_in.upper_mm   = csr_pwdata[CFG_WIDTH-1:0];
            REG_MIN_DIST:      cfg_in.closest_mm = csr_pwdata[CFG_WIDTH-1:0];
            REG_NEIGHBOR_DIST: cfg_in.support_mm = csr_pwdata[CFG_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_RANGE_MIN:     csr_prdata = CSR_DATA_BITS'(cfg_ff.lower_mm);
         REG_RANGE_MAX:     csr_prdata = CSR_DATA_BITS'(cfg_ff.upper_mm);
         REG_MIN_DIST:      csr_prdata = CSR_DATA_BITS'(cfg_ff.closest_mm);
         REG_NEIGHBOR_DIST: csr_prdata = CSR_DATA_BITS'(cfg_ff.support_mm);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_mm   <= RANGE_MIN_RESET;
         cfg_ff.upper_mm   <= RANGE_MAX_RESET;
         cfg_ff.closest_mm <= MIN_DIST_RESET;
         cfg_ff.support_mm <= NEIGHBOR_DIST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/srof_decide.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter decision
// Accept or reject one sample given its left and right neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srof_decide
   import srof_pkg::*;
#(
   parameter int RANGE_BITS = 16
) (
   input  cfg_type               cfg,
   input  logic [RANGE_BITS-1:0] x,
   input  logic                  x_nr,
   input  logic                  left_present,
   input  logic [RANGE_BITS-1:0] left_range,
   input  logic                  left_nr,
   input  logic                  right_present,
   input  logic [RANGE_BITS-1:0] right_range,
   input  logic                  right_nr,
   output logic [RANGE_BITS-1:0] filt,
   output logic                  filt_nr,
   output logic                  rej
);

   localparam int CW = (RANGE_BITS > CFG_WIDTH) ? RANGE_BITS : CFG_WIDTH;

   logic [CW-1:0]         x_w;
   logic [CW-1:0]         l_w;
   logic [CW-1:0]         r_w;
   logic [CW-1:0]         min_w;
   logic [CW-1:0]         max_w;
   logic [CW-1:0]         md_w;
   logic [CW-1:0]         nd_w;
   logic [CW:0]           repl_wide;
   logic [RANGE_BITS-1:0] repl;
   logic [RANGE_BITS-1:0] diff_l;
   logic [RANGE_BITS-1:0] diff_r;
   logic                  valid_l;
   logic                  valid_r;
   logic                  far_l;
   logic                  far_r;

   assign x_w   = CW'(x);
   assign l_w   = CW'(left_range);
   assign r_w   = CW'(right_range);
   assign min_w = CW'(cfg.lower_mm);
   assign max_w = CW'(cfg.upper_mm);
   assign md_w  = CW'(cfg.closest_mm);
   assign nd_w  = CW'(cfg.support_mm);

   assign repl_wide = (CW+1)'(max_w) + (CW+1)'(1);
   assign repl      = (|repl_wide[CW:RANGE_BITS]) ? '1 : repl_wide[RANGE_BITS-1:0];

   assign valid_l = left_present && !left_nr && (l_w > min_w) && (l_w < max_w);
   assign valid_r = right_present && !right_nr && (r_w > min_w) && (r_w < max_w);

   assign diff_l = (left_range > x) ? left_range - x : x - left_range;
   assign diff_r = (right_range > x) ? right_range - x : x - right_range;

   assign far_l = !left_present ||
                  (!left_nr && !x_nr && (CW'(diff_l) > nd_w));
   assign far_r = !right_present ||
                  (!right_nr && !x_nr && (CW'(diff_r) > nd_w));

   always_comb begin
      priority if (!x_nr && ((x_w > max_w) || (x_w < min_w))) begin
         rej = 1'b0;
      end else if (!x_nr && (x_w < md_w)) begin
         rej = 1'b1;
      end else if (!valid_l && !valid_r) begin
         rej = 1'b1;
      end else if (far_l && far_r) begin
         rej = 1'b1;
      end else begin
         rej = 1'b0;
      end
   end

   always_comb begin
      if (rej) begin
         filt    = repl;
         filt_nr = 1'b0;
      end else begin
         filt    = x_nr ? '0 : x;
         filt_nr = x_nr;
      end
   end

endmodule

@@ rtl/srof_outq.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter result queue
// Four-entry queue taking up to two results per cycle, giving one when read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scan_range_outlier_filter_unit_macros.svh"

module srof_outq
   import srof_pkg::*;
#(
   parameter int WIDTH = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  logic [WIDTH-1:0] push_data0,
   input  logic [WIDTH-1:0] push_data1,
   output logic             room,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0]       entry_ff [OQ_DEPTH];
   logic [OQ_PTR_BITS-1:0] wr_ptr_ff;
   logic [OQ_PTR_BITS-1:0] wr_ptr_in;
   logic [OQ_PTR_BITS-1:0] rd_ptr_ff;
   logic [OQ_PTR_BITS-1:0] rd_ptr_in;
   logic [OQ_CNT_BITS-1:0] count_ff;
   logic [OQ_CNT_BITS-1:0] count_in;
   logic                   pop;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;
   assign room     = (count_ff <= OQ_CNT_BITS'(OQ_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + OQ_PTR_BITS'(push_count);
   assign rd_ptr_in = rd_ptr_ff + OQ_PTR_BITS'(pop);
   assign count_in  = count_ff + OQ_CNT_BITS'(push_count) - OQ_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + OQ_PTR_BITS'(1)] <= push_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SROF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= OQ_CNT_BITS'(OQ_DEPTH), "result queue count beyond depth")
   `SROF_ASSERT_NXT(a_pop_only_drains, clock, reset, pop && (push_count == 2'd0), count_ff == $past(count_ff) - OQ_CNT_BITS'(1), "result queue count did not drop on a lone pop")
   `SROF_ASSERT_NXT(a_empty_push_shows, clock, reset, (count_ff == '0) && (push_count != 2'd0), rd_valid && (rd_data == $past(push_data0)), "pushed result did not reach the head")

endmodule

@@ rtl/srof_core.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter core
// Input register, held sample and left neighbor state, and the two
// decisions that one sample can complete.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scan_range_outlier_filter_unit_macros.svh"

module srof_core
   import srof_pkg::*;
#(
   parameter int RANGE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [RANGE_BITS-1:0]   req_range_mm,
   input  logic                    req_no_return,
   input  logic                    req_scan_end,
   input  logic                    room,
   output logic [1:0]              push_count,
   output logic [RANGE_BITS+2:0]   push_data0,
   output logic [RANGE_BITS+2:0]   push_data1
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [RANGE_BITS-1:0] in_range_ff;
   logic                  in_nr_ff;
   logic                  in_end_ff;

   logic [RANGE_BITS-1:0] left_range_ff;
   logic [RANGE_BITS-1:0] left_range_in;
   logic                  left_nr_ff;
   logic                  left_nr_in;
   logic [RANGE_BITS-1:0] held_range_ff;
   logic [RANGE_BITS-1:0] held_range_in;
   logic                  held_nr_ff;
   logic                  held_nr_in;
   logic                  held_present_ff;
   logic                  held_present_in;
   logic                  held_first_ff;
   logic                  held_first_in;

   logic                  fire;
   logic                  take;
   logic                  had;
   logic [RANGE_BITS-1:0] held_filt;
   logic                  held_filt_nr;
   logic                  held_rej;
   logic [RANGE_BITS-1:0] left_after;
   logic                  left_after_nr;
   logic [RANGE_BITS-1:0] last_filt;
   logic                  last_filt_nr;
   logic                  last_rej;
   logic [RANGE_BITS+2:0] held_res;
   logic [RANGE_BITS+2:0] last_res;

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign take      = req_valid && req_ready;
   assign had       = held_present_ff;

   srof_decide #(.RANGE_BITS(RANGE_BITS)) u_held_decide (
      .cfg           (cfg),
      .x             (held_range_ff),
      .x_nr          (held_nr_ff),
      .left_present  (!held_first_ff),
      .left_range    (left_range_ff),
      .left_nr       (left_nr_ff),
      .right_present (1'b1),
      .right_range   (in_range_ff),
      .right_nr      (in_nr_ff),
      .filt          (held_filt),
      .filt_nr       (held_filt_nr),
      .rej           (held_rej)
   );

   assign left_after    = had ? held_filt : left_range_ff;
   assign left_after_nr = had ? held_filt_nr : left_nr_ff;

   srof_decide #(.RANGE_BITS(RANGE_BITS)) u_last_decide (
      .cfg           (cfg),
      .x             (in_range_ff),
      .x_nr          (in_nr_ff),
      .left_present  (had),
      .left_range    (left_after),
      .left_nr       (left_after_nr),
      .right_present (1'b0),
      .right_range   ('0),
      .right_nr      (1'b0),
      .filt          (last_filt),
      .filt_nr       (last_filt_nr),
      .rej           (last_rej)
   );

   assign held_res = {held_filt, held_filt_nr, held_rej, 1'b0};
   assign last_res = {last_filt, last_filt_nr, last_rej, 1'b1};

   always_comb begin
      push_count = 2'd0;
      if (fire) begin
         push_count = {1'b0, had} + {1'b0, in_end_ff};
      end
      push_data0 = had ? held_res : last_res;
      push_data1 = last_res;
   end

   always_comb begin
      in_valid_in     = take || (in_valid_ff && !fire);
      left_range_in   = left_range_ff;
      left_nr_in      = left_nr_ff;
      held_range_in   = held_range_ff;
      held_nr_in      = held_nr_ff;
      held_present_in = held_present_ff;
      held_first_in   = held_first_ff;
      if (fire) begin
         if (in_end_ff) begin
            left_range_in   = '0;
            left_nr_in      = 1'b0;
            held_range_in   = '0;
            held_nr_in      = 1'b0;
            held_present_in = 1'b0;
            held_first_in   = 1'b0;
         end else begin
            left_range_in   = left_after;
            left_nr_in      = left_after_nr;
            held_range_in   = in_range_ff;
            held_nr_in      = in_nr_ff;
            held_present_in = 1'b1;
            held_first_in   = !had;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_range_ff <= req_range_mm;
         in_nr_ff    <= req_no_return;
         in_end_ff   <= req_scan_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         left_range_ff   <= '0;
         left_nr_ff      <= 1'b0;
         held_range_ff   <= '0;
         held_nr_ff      <= 1'b0;
         held_present_ff <= 1'b0;
         held_first_ff   <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         left_range_ff   <= left_range_in;
         left_nr_ff      <= left_nr_in;
         held_range_ff   <= held_range_in;
         held_nr_ff      <= held_nr_in;
         held_present_ff <= held_present_in;
         held_first_ff   <= held_first_in;
      end
   end

   `SROF_ASSERT_IMP(a_pair_needs_held, clock, reset, push_count == 2'd2, held_present_ff && in_end_ff, "two results without a held sample at scan end")
   `SROF_ASSERT_NXT(a_end_clears_hold, clock, reset, fire && in_end_ff, !held_present_ff && !held_first_ff, "scan end left a sample held")
   `SROF_ASSERT_NXT(a_sample_held, clock, reset, fire && !in_end_ff, held_present_ff && (held_range_ff == $past(in_range_ff)), "sample not held after transfer")

endmodule

@@ rtl/scan_range_outlier_filter_unit.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter unit
// Path: a scan-end sample passes the input register and result queue, behind
// the result of any held sample that goes out ahead of it; any other sample
// waits for the next sample's transfer, then leaves through the result queue.
// Throughput: one sample per cycle while the result queue has room, set by
// the single decision stage; a scan end that finds a sample held emits two
// results, drained through a four-entry result queue.
// Reset: synchronous, clears thresholds to defaults and drops any held sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_range_outlier_filter_unit
   import srof_pkg::*;
#(
   parameter int RANGE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RANGE_BITS-1:0]    req_range_mm,
   input  logic                     req_no_return,
   input  logic                     req_scan_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [RANGE_BITS-1:0]    rsp_filtered_mm,
   output logic                     rsp_out_no_return,
   output logic                     rsp_rejected,
   output logic                     rsp_out_scan_end,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int RES_WIDTH = RANGE_BITS + 3;

   cfg_type              cfg;
   logic                 room;
   logic [1:0]           push_count;
   logic [RES_WIDTH-1:0] push_data0;
   logic [RES_WIDTH-1:0] push_data1;
   logic [RES_WIDTH-1:0] rd_data;

   srof_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srof_core #(.RANGE_BITS(RANGE_BITS)) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_range_mm  (req_range_mm),
      .req_no_return (req_no_return),
      .req_scan_end  (req_scan_end),
      .room          (room),
      .push_count    (push_count),
      .push_data0    (push_data0),
      .push_data1    (push_data1)
   );

   srof_outq #(.WIDTH(RES_WIDTH)) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .room       (room),
      .rd_valid   (rsp_valid),
      .rd_ready   (rsp_ready),
      .rd_data    (rd_data)
   );

   assign rsp_filtered_mm   = rd_data[RES_WIDTH-1:3];
   assign rsp_out_no_return = rd_data[2];
   assign rsp_rejected      = rd_data[1];
   assign rsp_out_scan_end  = rd_data[0];

endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Scan range outlier filter unit testbench
// Streams scans of range samples through the filter. A driver takes samples
// from a queue and a monitor checks every result transfer against a
// prediction of the three-sample window decision. Thresholds are changed
// between phases over the register port while the unit is idle. Both sides
// idle in random bursts, except in the last phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import srof_pkg::*;

   localparam int RB         = 16;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [RB-1:0] range_mm;
      logic          no_return;
      logic          scan_end;
   } sample_type;

   typedef struct packed {
      logic [RB-1:0] filtered_mm;
      logic          no_return;
      logic          rejected;
      logic          scan_end;
   } result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [RB-1:0]            req_range_mm = '0;
   logic                     req_no_return = 1'b0;
   logic                     req_scan_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [RB-1:0]            rsp_filtered_mm;
   logic                     rsp_out_no_return;
   logic                     rsp_rejected;
   logic                     rsp_out_scan_end;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   scan_range_outlier_filter_unit #(.RANGE_BITS(RB)) dut (.*);

   always #2 clock = ~clock;

   sample_type samples_to_send[$];
   result_type filtered_due[$];
   sample_type sample_on_bus;
   cfg_type thresholds = '{RANGE_MIN_RESET, RANGE_MAX_RESET, MIN_DIST_RESET,
                           NEIGHBOR_DIST_RESET};
   bit      idle_enable = 1'b1;
   int      mismatch_count = 0;
   int      send_gap = 0;
   int      stall_gap = 0;
   int      quiet_cycles = 0;

   logic [RB-1:0] left_range = '0;
   bit            left_no_return = 1'b0;
   logic [RB-1:0] held_range = '0;
   bit            held_no_return = 1'b0;
   bit            held_present = 1'b0;
   bit            held_is_first = 1'b0;

   function automatic bit neighbor_valid(bit present, logic [RB-1:0] r, bit nr);
      return present && !nr && r > thresholds.lower_mm && r < thresholds.upper_mm;
   endfunction

   function automatic bit neighbor_far(bit present, logic [RB-1:0] r, bit nr,
                                       logic [RB-1:0] x, bit xnr);
      logic [RB-1:0] diff;
      if (!present) return 1'b1;
      if (nr || xnr) return 1'b0;
      diff = (r > x) ? r - x : x - r;
      return diff > thresholds.support_mm;
   endfunction

   function automatic result_type filter_decision(logic [RB-1:0] x, bit xnr,
                                                  bit lp, logic [RB-1:0] l, bit lnr,
                                                  bit rp, logic [RB-1:0] r, bit rnr,
                                                  bit last);
      result_type res;
      bit      rej;
      logic [RB:0] repl;
      repl = {1'b0, thresholds.upper_mm} + 1'b1;
      if (repl > {1'b0, {RB{1'b1}}}) repl = {1'b0, {RB{1'b1}}};
      if (!xnr && (x > thresholds.upper_mm || x < thresholds.lower_mm)) begin
         rej = 1'b0;
      end else if (!xnr && x < thresholds.closest_mm) begin
         rej = 1'b1;
      end else if (!neighbor_valid(lp, l, lnr) && !neighbor_valid(rp, r, rnr)) begin
         rej = 1'b1;
      end else begin
         rej = neighbor_far(lp, l, lnr, x, xnr) && neighbor_far(rp, r, rnr, x, xnr);
      end
      res.filtered_mm = rej ? repl[RB-1:0] : (xnr ? '0 : x);
      res.no_return   = !rej && xnr;
      res.rejected    = rej;
      res.scan_end    = last;
      return res;
   endfunction

   function automatic void advance_scan_window(sample_type s);
      result_type res;
      bit      had;
      had = held_present;
      if (had) begin
         res = filter_decision(held_range, held_no_return, !held_is_first, left_range,
                               left_no_return, 1'b1, s.range_mm, s.no_return, 1'b0);
         left_range     = res.filtered_mm;
         left_no_return = res.no_return;
         filtered_due.push_back(res);
      end
      if (s.scan_end) begin
         res = filter_decision(s.range_mm, s.no_return, had, left_range, left_no_return,
                               1'b0, '0, 1'b0, 1'b1);
         filtered_due.push_back(res);
         left_range     = '0;
         left_no_return = 1'b0;
         held_range     = '0;
         held_no_return = 1'b0;
         held_present   = 1'b0;
         held_is_first  = 1'b0;
      end else begin
         held_range     = s.range_mm;
         held_no_return = s.no_return;
         held_is_first  = !had;
         held_present   = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_scan_window(sample_on_bus);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
               send_gap  <= $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
               sample_on_bus = samples_to_send.pop_front();
               req_range_mm  <= sample_on_bus.range_mm;
               req_no_return <= sample_on_bus.no_return;
               req_scan_end  <= sample_on_bus.scan_end;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string field, int expected, int actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (filtered_due.size() == 0) begin
               $display("%0t ns: unexpected result transfer, filtered_mm %0d",
                        $time, rsp_filtered_mm);
               mismatch_count++;
            end else begin
               want = filtered_due.pop_front();
               check_field("filtered_mm", int'(want.filtered_mm), int'(rsp_filtered_mm));
               check_field("out_no_return", int'(want.no_return), int'(rsp_out_no_return));
               check_field("rejected", int'(want.rejected), int'(rsp_rejected));
               check_field("out_scan_end", int'(want.scan_end), int'(rsp_out_scan_end));
            end
         end
         if (stall_gap != 0) begin
            stall_gap <= stall_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            stall_gap <= $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(csr_reg_type which, logic [CFG_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({which, 2'b00});
      csr_pwdata  <= CSR_DATA_BITS'({$urandom, value});
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (which)
         REG_RANGE_MIN:     thresholds.lower_mm = value;
         REG_RANGE_MAX:     thresholds.upper_mm = value;
         REG_MIN_DIST:      thresholds.closest_mm = value;
         REG_NEIGHBOR_DIST: thresholds.support_mm = value;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(int lo, int hi, int closest, int spread);
      csr_write(REG_RANGE_MIN, CFG_WIDTH'(lo));
      csr_write(REG_RANGE_MAX, CFG_WIDTH'(hi));
      csr_write(REG_MIN_DIST, CFG_WIDTH'(closest));
      csr_write(REG_NEIGHBOR_DIST, CFG_WIDTH'(spread));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (samples_to_send.size() != 0 || req_valid || filtered_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic add_sample(int range, int nr, int last);
      samples_to_send.push_back('{RB'(range), nr != 0, last != 0});
   endtask

   task automatic add_random_scans(int quota);
      sample_type s;
      int      scan_len;
      int      level;
      int      span;
      while (quota > 0) begin
         scan_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
         if (thresholds.lower_mm < thresholds.upper_mm)
            level = $urandom_range(int'(thresholds.lower_mm), int'(thresholds.upper_mm));
         else
            level = $urandom_range(0, 65535);
         span = (thresholds.support_mm > 2000) ? 2000 : int'(thresholds.support_mm) + 3;
         for (int k = 0; k < scan_len; k++) begin
            case ($urandom_range(0, 15))
               0: s.range_mm = RB'($urandom);
               1: s.range_mm = $urandom_range(0, 1) ? '1 : '0;
               2: s.range_mm = RB'($urandom_range(0, int'(thresholds.closest_mm)));
               3: s.range_mm = RB'(level + 3 * span + $urandom_range(1, 5000));
               default: begin
                  level = level + int'($urandom_range(0, 2 * span)) - span;
                  if (level < 0) level = 0;
                  if (level > 65535) level = 65535;
                  s.range_mm = RB'(level);
               end
            endcase
            s.no_return = ($urandom_range(0, 9) == 0);
            s.scan_end  = (k == scan_len - 1);
            samples_to_send.push_back(s);
         end
         quota -= scan_len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset thresholds: scan ends, lone samples and extreme ranges.
      add_sample(1000, 0, 1);
      add_sample(0, 1, 1);
      add_sample(40000, 0, 1);
      add_sample(65535, 0, 1);
      add_sample(0, 0, 1);
      add_sample(1000, 0, 0);
      add_sample(1000, 0, 0);
      add_sample(1000, 0, 1);
      add_sample(1000, 0, 0);
      add_sample(2000, 0, 0);
      add_sample(1000, 0, 1);
      add_sample(1000, 0, 0);
      add_sample(0, 1, 0);
      add_sample(1000, 0, 1);
      wait_drained();

      set_thresholds(100, 5000, 300, 50);
      add_sample(200, 0, 0);
      add_sample(250, 0, 0);
      add_sample(210, 0, 1);
      add_sample(50, 0, 1);
      add_sample(1000, 0, 0);
      add_sample(1200, 0, 0);
      add_sample(1400, 0, 1);
      add_sample(1000, 0, 0);
      add_sample(1040, 0, 0);
      add_sample(1020, 0, 1);
      add_sample(0, 1, 0);
      add_sample(777, 1, 0);
      add_sample(1010, 0, 1);
      wait_drained();

      set_thresholds(0, 65534, 0, 65535);
      add_random_scans(200);
      wait_drained();

      set_thresholds(65534, 0, 65535, 0);
      add_random_scans(100);
      wait_drained();

      for (int p = 0; p < 3; p++) begin
         set_thresholds($urandom_range(0, 2000), $urandom_range(5000, 40000),
                        $urandom_range(0, 3000), $urandom_range(0, 2000));
         add_random_scans(200);
         wait_drained();
      end

      // A top range of all ones makes the replacement value saturate.
      set_thresholds($urandom_range(0, 500), 65535, $urandom_range(0, 500),
                     $urandom_range(0, 1000));
      add_random_scans(100);
      wait_drained();

      idle_enable = 1'b0;
      set_thresholds($urandom_range(0, 2000), $urandom_range(5000, 40000),
                     $urandom_range(0, 3000), $urandom_range(0, 2000));
      add_random_scans(200);
      wait_drained();

      if (mismatch_count == 0 && filtered_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
